// ----- src/deq_pkg.sv -----
// Package for the double-ended queue: payload structs, operation and status codes.
// Used by double_ended_queue; no dependencies of its own.
package deq_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned COUNT_W = 5;

    typedef logic [1:0] t_op;
    typedef logic [1:0] t_status;

    localparam t_op OP_ADD_FRONT = 2'd0;
    localparam t_op OP_ADD_BACK  = 2'd1;
    localparam t_op OP_REM_FRONT = 2'd2;
    localparam t_op OP_REM_BACK  = 2'd3;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_UNDERFLOW = 2'd1;
    localparam t_status ST_OVERFLOW  = 2'd2;

    typedef struct packed {
        t_op                       op;
        logic signed [DATA_W-1:0]  data_in;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0]  data_out;
        t_status                   status;
        logic                      is_empty;
        logic [COUNT_W-1:0]        count_now;
    } t_out;

endpackage

// ----- src/deq_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies. Read during a write to the same entry returns the old word.
module deq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/double_ended_queue.sv -----
// Double-ended queue over a ring buffer held in one RAM (deq_ram).
// Depends on deq_pkg for payload structs and op/status codes.
//
//  channel | valid   | ready   | payload | direction
//  --------+---------+---------+---------+----------
//  request | i_valid | o_ready | i_data  | in
//  result  | o_valid | i_ready | o_data  | out
//
// One request per cycle unless the result side stalls; results pass s1, then r_out.
// Pointers and count update at the request beat; RAM read data lands in the cycle after.
// Adds and removes never share a cycle, so the RAM needs no forwarding.
// Reset (synchronous, active low) empties the queue; slot contents are not cleared.
// A stalled result holds a one-deep stage behind it, then the request side stalls.
module double_ended_queue #(
    parameter int unsigned DEPTH      = 16,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  deq_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output deq_pkg::t_out o_data
);

    localparam int unsigned AW  = $clog2(DEPTH);
    localparam int unsigned CW  = $clog2(DEPTH + 1);
    localparam int unsigned CXW = (CW > deq_pkg::COUNT_W) ? CW : deq_pkg::COUNT_W;
    localparam int unsigned DXW = (DATA_WIDTH > deq_pkg::DATA_W) ? DATA_WIDTH
                                                                 : deq_pkg::DATA_W;

    logic [AW-1:0] r_front, n_front;
    logic [AW-1:0] r_back,  n_back;
    logic [CW-1:0] r_count, n_count;

    logic                         r_s1_valid;
    logic                         r_s1_rd_ok, n_s1_rd_ok;
    deq_pkg::t_status             r_s1_status, n_s1_status;
    logic [deq_pkg::COUNT_W-1:0]  r_s1_count;
    logic                         r_s1_empty;

    logic          r_out_valid;
    deq_pkg::t_out r_out;

    logic                  w_in_acc, w_s1_move;
    logic                  w_full, w_empty;
    logic [AW-1:0]         w_front_prev, w_front_next, w_back_prev, w_back_next;
    logic                  w_we, w_re;
    logic [AW-1:0]         w_waddr, w_raddr;
    logic [DXW-1:0]        w_in_x, w_rd_x;
    logic [CXW-1:0]        w_count_x;
    logic [DATA_WIDTH-1:0] w_rdata;

    // handshake
    assign w_s1_move = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_s1_valid || w_s1_move;
    assign w_in_acc  = i_valid && o_ready;

    assign w_full  = (r_count == CW'(DEPTH));
    assign w_empty = (r_count == '0);

    assign w_front_prev = (r_front == '0) ? AW'(DEPTH - 1) : r_front - AW'(1);
    assign w_front_next = (r_front == AW'(DEPTH - 1)) ? '0 : r_front + AW'(1);
    assign w_back_prev  = (r_back == '0) ? AW'(DEPTH - 1) : r_back - AW'(1);
    assign w_back_next  = (r_back == AW'(DEPTH - 1)) ? '0 : r_back + AW'(1);

    assign w_waddr = (i_data.op == deq_pkg::OP_ADD_FRONT) ? w_front_prev : r_back;
    assign w_raddr = (i_data.op == deq_pkg::OP_REM_FRONT) ? r_front : w_back_prev;

    // word is stored zero-extended or truncated to the RAM width
    assign w_in_x = DXW'($unsigned(i_data.data_in));

    always_comb begin
        n_front     = r_front;
        n_back      = r_back;
        n_count     = r_count;
        n_s1_rd_ok  = 1'b0;
        n_s1_status = deq_pkg::ST_OK;
        w_we        = 1'b0;
        w_re        = 1'b0;
        case (i_data.op)
            deq_pkg::OP_ADD_FRONT: begin
                if (w_full) begin
                    n_s1_status = deq_pkg::ST_OVERFLOW;
                end else begin
                    w_we    = w_in_acc;
                    n_front = w_front_prev;
                    n_count = r_count + CW'(1);
                end
            end
            deq_pkg::OP_ADD_BACK: begin
                if (w_full) begin
                    n_s1_status = deq_pkg::ST_OVERFLOW;
                end else begin
                    w_we    = w_in_acc;
                    n_back  = w_back_next;
                    n_count = r_count + CW'(1);
                end
            end
            deq_pkg::OP_REM_FRONT: begin
                if (w_empty) begin
                    n_s1_status = deq_pkg::ST_UNDERFLOW;
                end else begin
                    w_re       = w_in_acc;
                    n_s1_rd_ok = 1'b1;
                    n_front    = w_front_next;
                    n_count    = r_count - CW'(1);
                end
            end
            deq_pkg::OP_REM_BACK: begin
                if (w_empty) begin
                    n_s1_status = deq_pkg::ST_UNDERFLOW;
                end else begin
                    w_re       = w_in_acc;
                    n_s1_rd_ok = 1'b1;
                    n_back     = w_back_prev;
                    n_count    = r_count - CW'(1);
                end
            end
            default: begin
                n_s1_status = deq_pkg::ST_OK;
            end
        endcase
    end

    assign w_count_x = CXW'(n_count);

    deq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_in_x[DATA_WIDTH-1:0]),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd_x = DXW'(w_rdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_back      <= '0;
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_front <= n_front;
                r_back  <= n_back;
                r_count <= n_count;
            end
            if (w_in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_rd_ok  <= n_s1_rd_ok;
            r_s1_status <= n_s1_status;
            r_s1_count  <= w_count_x[deq_pkg::COUNT_W-1:0];
            // taken from the full-width count, the reported field may wrap
            r_s1_empty  <= (n_count == '0);
        end
        if (w_s1_move) begin
            r_out.data_out  <= r_s1_rd_ok ? w_rd_x[deq_pkg::DATA_W-1:0] : '0;
            r_out.status    <= r_s1_status;
            r_out.is_empty  <= r_s1_empty;
            r_out.count_now <= r_s1_count;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

`ifndef ASSERT_OFF
    logic [AW:0] w_span;
    assign w_span = (r_back >= r_front)
                  ? {1'b0, r_back} - {1'b0, r_front}
                  : {1'b0, r_back} + (AW+1)'(DEPTH) - {1'b0, r_front};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("held count above depth");

    a_ring_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CW'(w_span) == r_count) || (w_span == '0 && r_count == CW'(DEPTH)))
        else $error("pointers disagree with held count");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_in_acc |=> $stable(r_count))
        else $error("count changed without a request beat");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_we && w_re))
        else $error("RAM read and write in one cycle");

    a_s1_hold_rdata: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_rd_ok && !w_s1_move) |=> $stable(w_rdata))
        else $error("read data lost while result stage stalled");
`endif

endmodule
